[src/positional_list_engine_macros.svh]
// Assertion helpers for the positional list engine.
// Each helper samples on clk and is disabled while rst_n is low.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define PLE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_list_engine: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_list_engine: next-cycle check failed");

`else

`define PLE_ASSERT_SAME(lbl, ante, cons)
`define PLE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/ple_pkg.sv]
package ple_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int LEN_W        = 7;
  localparam int CAPACITY_DEF = 64;
  // cells per first-level group of the read gather
  localparam int GROUP        = 8;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_REM  = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [POS_W-1:0] position;
    data_t            value_in;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    data_t            value_out;
    logic [LEN_W-1:0] length;
  } out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    data_t            val;
  } cell_ctl_t;

endpackage

[src/ple_cell.sv]
module ple_cell import ple_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  data_t     left,
  input  data_t     right,
  output data_t     slot,
  output data_t     hit
);

  data_t slot_r;
  data_t slot_nxt;
  data_t hit_r;
  logic  at_pos;
  logic  past_pos;

  assign at_pos   = (32'(ctl.pos) == 32'(INDEX));
  assign past_pos = (32'(INDEX) > 32'(ctl.pos));

  always_comb begin
    slot_nxt = slot_r;
    unique case (ctl.op)
      CELL_INS: begin
        if (at_pos) begin
          slot_nxt = ctl.val;
        end else if (past_pos) begin
          slot_nxt = left;
        end
      end
      CELL_REM: begin
        if (at_pos || past_pos) begin
          slot_nxt = right;
        end
      end
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    // offer the held entry to the gather when this cell is addressed
    hit_r  <= at_pos ? slot_r : '0;
  end

  assign slot = slot_r;
  assign hit  = hit_r;

endmodule

[src/ple_gather.sv]
module ple_gather import ple_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic  clk,
  input  data_t hits [CAPACITY],
  output data_t data
);

  localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;

  data_t grp_r [NGRP];

  // at most one cell offers a non-zero word, so OR acts as the select
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      data_t acc;
      acc = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          acc = acc | hits[g * GROUP + k];
        end
      end
      grp_r[g] <= acc;
    end
  end

  always_comb begin
    data = '0;
    for (int g = 0; g < NGRP; g++) begin
      data = data | grp_r[g];
    end
  end

endmodule

[src/positional_list_engine.sv]
// Positional list engine: an ordered list of signed 32-bit entries held in a
// row of CAPACITY cells, one entry per cell. A command transfers in on a
// rising edge with start high and busy low; busy then stays high through the
// EXEC, GATH and FIN states, so no new command is taken before the last is
// done. Insert shifts every cell above the position up by one neighbour at
// once in EXEC, remove shifts them down, clear only resets the length. A read
// is gathered from the row through the cell hit registers and a two-level OR
// tree whose group level is registered. Exactly one result per command shows
// on out_item with out_strobe high for one cycle, as busy falls; the receiver
// cannot stall, so it must take every transfer as it comes. Entries beyond the
// current length are never reported and need no clearing after reset.
`include "positional_list_engine_macros.svh"

module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_GATH = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_strobe_r;
  out_t             out_item_r;

  // command held for the whole operation
  logic [1:0]       cmd_r;
  logic [POS_W-1:0] pos_r;
  data_t            val_r;
  logic [1:0]       status_r, status_nxt;

  cell_ctl_t ctl;
  data_t     slot_q [CAPACITY];
  data_t     hit_q  [CAPACITY];
  data_t     gathered;
  logic      accept;
  logic [31:0] pos32, cnt32, len32;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign pos32  = 32'(pos_r);
  assign cnt32  = 32'(count_r);

  // decide status and the new length from the held command
  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    ctl.op     = CELL_HOLD;
    ctl.pos    = pos_r;
    ctl.val    = val_r;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (pos32 > cnt32) begin
          status_nxt = ST_BADPOS;
        end else if (cnt32 >= 32'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          ctl.op    = (state_r == S_EXEC) ? CELL_INS : CELL_HOLD;
        end
      end
      CMD_REMOVE: begin
        if (pos32 >= cnt32) begin
          status_nxt = ST_BADPOS;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          ctl.op    = (state_r == S_EXEC) ? CELL_REM : CELL_HOLD;
        end
      end
      CMD_READ: begin
        if (pos32 >= cnt32) begin
          status_nxt = ST_BADPOS;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_GATH;
      S_GATH:  state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_FIN);
      if (state_r == S_EXEC) begin
        count_r <= count_nxt;
      end
    end
  end

  assign len32 = 32'(count_r);

  // payload: hold the command, capture status, then present the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.cmd;
      pos_r <= in_item.position;
      val_r <= in_item.value_in;
    end
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
    end
    if (state_r == S_FIN) begin
      out_item_r.status    <= status_r;
      out_item_r.value_out <= (status_r == ST_OK && cmd_r == CMD_READ) ? gathered : '0;
      out_item_r.length    <= len32[LEN_W-1:0];
    end
  end

  // row of cells; each end cell sees zero beyond the row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = slot_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = slot_q[i+1];
    end
    ple_cell #(.INDEX(i)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .left  (left_d),
      .right (right_d),
      .slot  (slot_q[i]),
      .hit   (hit_q[i])
    );
  end

  ple_gather #(.CAPACITY(CAPACITY)) u_gather (
    .clk  (clk),
    .hits (hit_q),
    .data (gathered)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // checks on the sequencing, the list length and the zero value of a failed result
  `PLE_ASSERT_NEXT(a_accept_busy, accept, busy)
  `PLE_ASSERT_NEXT(a_fin_strobe, state_r == S_FIN, out_strobe && !busy)
  `PLE_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_r) <= 32'(CAPACITY))
  `PLE_ASSERT_SAME(a_bad_zero, out_strobe && out_item.status != ST_OK, out_item.value_out == '0)

endmodule
